>>> rtl/ppmn_pkg.sv
// Shared types and constants for the PPM stream negative filter.
package ppmn_pkg;

    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 16;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int COUNT_W = 34;

    localparam logic [BYTE_W-1:0] ASCII_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] PIXEL_MAX   = 8'hFF;
    localparam logic [DIM_W-1:0]  DIM_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_LINE1  = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_REST2  = 3'd3,
        PH_LINE3  = 3'd4,
        PH_PIXELS = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_pixel;
        logic              image_end;
    } result_t;

endpackage

>>> rtl/ppmn_core.sv
// Header parser, dimension capture and pixel inversion for the negative filter.
module ppmn_core #(
    parameter int LINE_LIMIT = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              in_byte,
    output ppmn_pkg::result_t       result
);
    import ppmn_pkg::*;

    localparam int LC_W = $clog2(LINE_LIMIT);

    phase_t               phase_reg, phase_next, phase_work;
    logic [LC_W-1:0]      line_count_reg, line_count_next, lc_inc;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [DIM_W-1:0]     height_reg, height_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [PROD_W-1:0]    product_reg;
    logic [COUNT_W-1:0]   last_idx_reg;
    logic                 digit;
    logic [3:0]           digit_val;
    logic                 line_done;
    logic                 last_pixel;

    function automatic logic [DIM_W-1:0] add_digit(input logic [DIM_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [DIM_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{DIM_W{1'b0}}, d};
        return (v > {4'b0000, DIM_MAX}) ? DIM_MAX : v[DIM_W-1:0];
    endfunction

    assign digit     = (in_byte >= ASCII_ZERO) && (in_byte <= ASCII_NINE);
    assign digit_val = 4'(in_byte - ASCII_ZERO);
    assign lc_inc    = line_count_reg + 1'b1;
    assign line_done = (in_byte == ASCII_LF) || (lc_inc >= LC_W'(LINE_LIMIT - 1));

    // An image holds at least three pixel bytes, so the first pixel is never the
    // last; the end index is ready from the second pixel on.
    assign last_pixel = (count_reg != '0) && (count_reg == last_idx_reg);

    always_comb
    begin
        result.out_byte  = in_byte;
        result.is_pixel  = 1'b0;
        result.image_end = 1'b0;
        if (phase_reg == PH_PIXELS)
        begin
            result.out_byte  = PIXEL_MAX - in_byte;
            result.is_pixel  = 1'b1;
            result.image_end = last_pixel;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        line_count_next = line_count_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        count_next      = count_reg;
        phase_work      = phase_reg;

        if (phase_reg == PH_PIXELS)
        begin
            if (last_pixel)
            begin
                phase_next      = PH_LINE1;
                line_count_next = '0;
                count_next      = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LINE1, PH_REST2, PH_LINE3: phase_work = phase_reg;
                PH_WIDTH:
                begin
                    if (digit)
                        width_next = add_digit(width_reg, digit_val);
                    else
                        phase_work = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    if (digit)
                        height_next = add_digit(height_reg, digit_val);
                    else
                        phase_work = PH_REST2;
                end
                default: phase_work = PH_LINE1;
            endcase

            if (!line_done)
            begin
                line_count_next = lc_inc;
                phase_next      = phase_work;
            end
            else
            begin
                line_count_next = '0;
                unique case (phase_work)
                    PH_LINE1:
                    begin
                        width_next  = '0;
                        height_next = '0;
                        phase_next  = PH_WIDTH;
                    end
                    PH_LINE3:
                    begin
                        count_next = '0;
                        phase_next = ((width_reg == '0) || (height_reg == '0)) ?
                                     PH_LINE1 : PH_PIXELS;
                    end
                    default: phase_next = PH_LINE3;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE1;
            line_count_reg <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            line_count_reg <= line_count_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            count_reg      <= count_next;
        end
    end

    // The dimensions settle by the end of line two, so the byte total follows
    // them through two register stages while line three is still being read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            product_reg  <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            product_reg  <= PROD_W'(width_reg) * PROD_W'(height_reg);
            last_idx_reg <= COUNT_W'({product_reg, 1'b0}) + COUNT_W'(product_reg)
                            - COUNT_W'(1);
        end
    end

    a_pixel_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> ((width_reg != '0) && (height_reg != '0)))
        else $error("pixel phase entered with a zero dimension");

    a_end_only_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        result.image_end |-> result.is_pixel)
        else $error("image end flagged on a header word");

    a_end_returns_line1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.image_end) |=> (phase_reg == PH_LINE1))
        else $error("no return to line one after the last pixel");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_PIXELS) && (count_reg != '0)) |-> (count_reg <= last_idx_reg))
        else $error("pixel count ran past the image size");

endmodule

>>> rtl/ppmn_skid.sv
// Output register with a skid stage for the negative filter result words.
module ppmn_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ppmn_pkg::result_t   push_data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ppmn_pkg::result_t   out_data
);
    import ppmn_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while the output register is empty");

    a_stall_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output word changed");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word not moved into the output register");

endmodule

>>> rtl/ppm_stream_negative.sv
// Top level of the PPM stream negative filter.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata) takes one byte of a binary
//   colour PPM file per word. The master channel returns one word for every
//   byte taken: header bytes unchanged with m_tuser low, pixel bytes as
//   255 minus the byte with m_tuser high, and m_tlast on the final pixel byte.
//   Header lines end at a newline or after LINE_LIMIT-1 bytes; width and height
//   come from the second line, and an image with no pixels goes straight back
//   to header parsing.
//   Each accepted byte's word is registered in the output or skid stage, and one word
//   is accepted in every cycle while s_tready is high; the parse state and pixel
//   counter update in a single step per byte. The byte total is formed by a two-stage
//   multiply that runs while the third header line is read.
//   Reset clears the parser to the first header line and empties the output.
//   When the receiver stalls, the output register and a one-word skid stage
//   hold results; s_tready drops only once both are full.
module ppm_stream_negative #(
    parameter int LINE_LIMIT = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic [0:0] m_tuser,     // [0] is_pixel
    output logic       m_tlast      // image_end
);
    import ppmn_pkg::*;

    logic    accept;
    result_t core_result;
    result_t out_word;

    assign accept = s_tvalid && s_tready;

    ppmn_core #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .result  (core_result)
    );

    ppmn_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_result),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_word)
    );

    assign m_tdata    = out_word.out_byte;
    assign m_tuser[0] = out_word.is_pixel;
    assign m_tlast    = out_word.image_end;

endmodule

>>> verif/ppmn_checker.sv
// Checker for the PPM stream negative filter: predicts every output word and compares it.
module ppmn_checker #(
    parameter int LINE_LIMIT = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [0:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending,
    output int         checked_words,
    output int         image_ends
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppmn_pkg::*;

    localparam int ACC_W     = DIM_W + 4;
    localparam int MAX_LINES = 50;

    // Predicted parser state.
    phase_t             phase_q;
    int                 line_len;
    logic [DIM_W-1:0]   width_q;
    logic [DIM_W-1:0]   height_q;
    logic [COUNT_W-1:0] left_q;

    result_t            expected_words[$];
    int                 errs  = 0;
    int                 words = 0;
    int                 ends  = 0;

    function automatic logic [DIM_W-1:0] add_digit(logic [DIM_W-1:0] acc, logic [7:0] b);
        logic [ACC_W-1:0] v;
        v = ACC_W'(acc) * ACC_W'(10) + ACC_W'(b - ASCII_ZERO);
        return (v > ACC_W'(DIM_MAX)) ? DIM_MAX : v[DIM_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errs < MAX_LINES)
            $display("[%0t] word %0d: %s is %0h, expected %0h", $realtime, words, what, got, want);
        errs++;
    endtask

    task automatic predict_word(input logic [7:0] b, output result_t r);
        logic digit;
        digit = (b >= ASCII_ZERO) && (b <= ASCII_NINE);
        r.out_byte  = b;
        r.is_pixel  = 1'b0;
        r.image_end = 1'b0;
        if (phase_q == PH_PIXELS)
        begin
            r.out_byte  = PIXEL_MAX - b;
            r.is_pixel  = 1'b1;
            r.image_end = (left_q <= 1);
            if (left_q != 0)
                left_q = left_q - 1'b1;
            if (left_q == 0)
            begin
                phase_q  = PH_LINE1;
                line_len = 0;
            end
            return;
        end
        case (phase_q)
            PH_WIDTH:
                if (digit)
                    width_q = add_digit(width_q, b);
                else
                    phase_q = PH_HEIGHT;
            PH_HEIGHT:
                if (digit)
                    height_q = add_digit(height_q, b);
                else
                    phase_q = PH_REST2;
            default: ;
        endcase
        line_len++;
        if (b != ASCII_LF && line_len < LINE_LIMIT - 1)
            return;
        line_len = 0;
        case (phase_q)
            PH_LINE1:
            begin
                width_q  = '0;
                height_q = '0;
                phase_q  = PH_WIDTH;
            end
            PH_LINE3:
            begin
                left_q  = COUNT_W'(width_q) * COUNT_W'(height_q) * COUNT_W'(3);
                phase_q = (left_q == 0) ? PH_LINE1 : PH_PIXELS;
            end
            default:
                phase_q = PH_LINE3;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            phase_q  = PH_LINE1;
            line_len = 0;
            width_q  = '0;
            height_q = '0;
            left_q   = '0;
        end
        else
        begin
            // The output side is handled first; a word leaving now was taken in earlier.
            if (m_tvalid && m_tready)
            begin
                got.out_byte  = m_tdata;
                got.is_pixel  = m_tuser[0];
                got.image_end = m_tlast;
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected, out_byte", got.out_byte, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.is_pixel != want.is_pixel)
                        report_mismatch("is_pixel", got.is_pixel, want.is_pixel);
                    if (got.image_end != want.image_end)
                        report_mismatch("image_end", got.image_end, want.image_end);
                    words++;
                    if (got.image_end)
                        ends++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_word(s_tdata, want);
                expected_words.push_back(want);
            end
        end
        fail_count    <= errs;
        pending       <= expected_words.size();
        checked_words <= words;
        image_ends    <= ends;
    end

endmodule

>>> verif/tb_ppm_stream_negative.sv
// Testbench top for the PPM stream negative filter: image stimulus, handshake idling, verdict.
module tb_ppm_stream_negative;
    timeunit 1ns;
    timeprecision 1ps;
    import ppmn_pkg::*;

    localparam int LINE_LIMIT   = 32;
    localparam int CYCLE_LIMIT  = 100_000;
    localparam int RANDOM_BYTES = 900;
    localparam int CALM_FROM    = 780;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_IMAGE   = 6;
    localparam int PAUSE_IMAGE  = 12;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int checked_words;
    int image_ends;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int sent     = 0;
    int images   = 0;

    ppm_stream_negative #(
        .LINE_LIMIT(LINE_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ppmn_checker #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_words (checked_words),
        .image_ends    (image_ends)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Run hit the cycle limit with %0d words still expected.", pending);
        $display("tb_ppm_stream_negative: errors");
        $finish;
    end

    function automatic logic [7:0] header_filler();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == ASCII_LF) ? 8'h20 : b;
    endfunction

    // A byte that ends a number on the size line without ending the line.
    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = header_filler();
        while (b >= ASCII_ZERO && b <= ASCII_NINE);
        return b;
    endfunction

    function automatic logic [7:0] pixel_value();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return PIXEL_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // A header line cut off by the length limit rather than by a newline.
    task automatic send_long_line();
        repeat (LINE_LIMIT - 1) send_byte(header_filler());
    endtask

    // The count from the checker is registered, so drop s_tvalid and let it catch up before looking.
    task automatic wait_all_out();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_image();
        int kind;
        int w;
        int h;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            // Junk of any content, then newlines to help the parser find its feet.
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(0, 255)));
            repeat (3) send_byte(ASCII_LF);
            return;
        end
        if (kind == 7)
            send_long_line();
        else
            send_text("P6\n");
        if (kind == 8)
        begin
            // Size lines that leave a zero dimension, so no pixels follow.
            case ($urandom_range(0, 3))
                0: send_text($sformatf("%0d\n", $urandom_range(0, 500)));
                1:
                begin
                    send_byte(non_digit());
                    send_text($sformatf("%0d\n", $urandom_range(0, 500)));
                end
                2: send_text($sformatf("%0d 0\n", $urandom_range(65536, 999999)));
                default: repeat (LINE_LIMIT - 1) send_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
            endcase
            send_text("255\n");
            return;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            w = $urandom_range(5, 40);
            h = 1;
        end
        else
        begin
            w = $urandom_range(0, 4);
            h = $urandom_range(0, 4);
        end
        repeat ($urandom_range(0, 2)) send_byte(ASCII_ZERO);
        send_text($sformatf("%0d", w));
        send_byte(non_digit());
        repeat ($urandom_range(0, 2)) send_byte(ASCII_ZERO);
        send_text($sformatf("%0d", h));
        if ($urandom_range(0, 1))
        begin
            send_byte(non_digit());
            repeat ($urandom_range(0, 8)) send_byte(header_filler());
        end
        send_byte(ASCII_LF);
        if (kind == 7)
            send_long_line();
        else if ($urandom_range(0, 1))
            send_text("255\n");
        else
            send_text($sformatf("%0d\n", $urandom_range(1, 65535)));
        repeat (3 * w * h) send_byte(pixel_value());
    endtask

    // Receiver: random stalls, one long hold on request, none near the end.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One pixel with the extreme byte values, then an image with zero width.
        send_text("P6\n1 1\n255\n");
        send_byte(8'h00);
        send_byte(PIXEL_MAX);
        send_byte(8'h5A);
        send_text("P6\n0 2\n\n");
        // A width past the 16-bit range with a zero height, so no pixels follow.
        send_text("P6\n70000 0\n255\n");
        images = 3;

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (images == HOLD_IMAGE)
                hold_req = 1'b1;
            if (images == PAUSE_IMAGE)
                wait_all_out();
            if (sent >= CALM_FROM)
                calm = 1'b1;
            send_image();
            images++;
        end

        wait_all_out();
        repeat (8) @(posedge clk);

        $display("Ran %0d images, %0d random bytes: %0d words checked, %0d image ends.",
                 images, sent, checked_words, image_ends);
        $display("Mix covered clamped sizes, empty images, overlong lines, junk and a long stall.");
        if (fail_count == 0 && pending == 0)
            $display("tb_ppm_stream_negative: clean");
        else
            $display("tb_ppm_stream_negative: errors");
        $finish;
    end

endmodule

>>> ppm_stream_negative.f
rtl/ppmn_pkg.sv
rtl/ppmn_core.sv
rtl/ppmn_skid.sv
rtl/ppm_stream_negative.sv
verif/ppmn_checker.sv
verif/tb_ppm_stream_negative.sv
